// ===== src/linear_scan_register_allocator_defines.svh =====
// Assertion helpers shared by the allocator RTL.
`ifndef LINEAR_SCAN_REGISTER_ALLOCATOR_DEFINES_SVH
`define LINEAR_SCAN_REGISTER_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, ignored while reset is high.
`define LSRA_ASSERT_HOLD(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lsra check failed");

// Next-cycle implication, checked during reset as well.
`define LSRA_ASSERT_NEXT(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("lsra check failed");

`endif

// ===== src/lsra_pkg.sv =====
package lsra_pkg;

  // Default sizes for the top-level parameters
  localparam int NUM_VREGS_DEF  = 256;
  localparam int NUM_PHYS_DEF   = 32;
  localparam int INDEX_BITS_DEF = 16;

  // Fixed field widths
  localparam int VREG_W     = 8;
  localparam int REQ_IDX_W  = 16;
  localparam int PRIO_W     = 16;
  localparam int LG_W       = 3;
  localparam int PHYS_OUT_W = 5;
  localparam int OFFSET_W   = 12;
  localparam int FRAME_W    = 13;
  localparam int MASK_W     = 32;
  localparam int SLOT_W     = 14;

  // Spill area
  localparam int SPILL_LIMIT = 4096;
  localparam logic [LG_W-1:0] SLOT_LG_MAX      = 3'd4;
  localparam logic [LG_W-1:0] SLOT_LG_FALLBACK = 3'd3;
  localparam logic [SLOT_W-1:0] FRAME_ROUND    = 14'd15;

  // Configuration registers
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALAR_MASK = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_VECTOR_MASK = 1'b1;
  localparam logic [MASK_W-1:0] SCALAR_RESET = 32'h0FFC_FFFF;
  localparam logic [MASK_W-1:0] VECTOR_RESET = 32'hFFFF_FF00;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_ACT_RD,
    ST_TAB_RD,
    ST_EVAL,
    ST_ALLOC,
    ST_COMMIT
  } lsra_state_t;

  typedef struct packed {
    logic capture;
    logic fill_step;
    logic tab_rd;
    logic eval;
    logic alloc;
    logic commit;
  } lsra_cmd_t;

  typedef struct packed {
    logic fill_last;
    logic walk_empty;
    logic walk_last;
    logic out_free;
    logic req_new;
  } lsra_stat_t;

endpackage

// ===== src/lsra_ifs.sv =====
interface lsra_req_if;
  logic        valid;
  logic        ready;
  logic        new_function;
  logic [7:0]  vreg_id;
  logic [15:0] start_req;
  logic [15:0] end_req;
  logic        needs_vector;
  logic [2:0]  slot_size_log2;
  logic [15:0] priority_req;

  modport source (output valid, new_function, vreg_id, start_req, end_req, needs_vector,
                  slot_size_log2, priority_req, input ready);
  modport sink (input valid, new_function, vreg_id, start_req, end_req, needs_vector,
                slot_size_log2, priority_req, output ready);
endinterface

interface lsra_res_if;
  logic        valid;
  logic        ready;
  logic [7:0]  vreg_out;
  logic        self_spilled;
  logic        is_vector;
  logic [4:0]  phys_reg;
  logic [11:0] slot_offset;
  logic        victim_valid;
  logic [7:0]  victim_vreg;
  logic [11:0] victim_offset;
  logic [12:0] frame_bytes;

  modport source (output valid, vreg_out, self_spilled, is_vector, phys_reg, slot_offset,
                  victim_valid, victim_vreg, victim_offset, frame_bytes, input ready);
  modport sink (input valid, vreg_out, self_spilled, is_vector, phys_reg, slot_offset,
                victim_valid, victim_vreg, victim_offset, frame_bytes, output ready);
endinterface

// ===== src/lsra_ram.sv =====
module lsra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/lsra_ctrl.sv =====
module lsra_ctrl
  import lsra_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_ready,
  input  lsra_stat_t stat,
  output lsra_cmd_t  cmd
);

  lsra_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_INIT:   if (stat.fill_last) state_next = ST_IDLE;
      ST_IDLE:   if (req_valid) state_next = stat.req_new ? ST_CLEAR : ST_ACT_RD;
      ST_CLEAR:  if (stat.fill_last) state_next = ST_ACT_RD;
      ST_ACT_RD: state_next = stat.walk_empty ? ST_ALLOC : ST_TAB_RD;
      ST_TAB_RD: state_next = ST_EVAL;
      ST_EVAL:   state_next = stat.walk_last ? ST_ALLOC : ST_TAB_RD;
      ST_ALLOC:  state_next = ST_COMMIT;
      ST_COMMIT: if (stat.out_free) state_next = ST_IDLE;
      default:   state_next = ST_INIT;
    endcase
  end

  // Commands to the datapath
  always_comb begin
    cmd       = '0;
    req_ready = 1'b0;
    unique case (state)
      ST_INIT:   cmd.fill_step = 1'b1;
      ST_IDLE: begin
        req_ready   = 1'b1;
        cmd.capture = req_valid;
      end
      ST_CLEAR:  cmd.fill_step = 1'b1;
      ST_ACT_RD: ;
      ST_TAB_RD: cmd.tab_rd = 1'b1;
      ST_EVAL:   cmd.eval = 1'b1;
      ST_ALLOC:  cmd.alloc = 1'b1;
      ST_COMMIT: cmd.commit = stat.out_free;
      default:   ;
    endcase
  end

endmodule

// ===== src/lsra_dp.sv =====
module lsra_dp
  import lsra_pkg::*;
#(
  parameter int NUM_VREGS  = NUM_VREGS_DEF,
  parameter int NUM_PHYS   = NUM_PHYS_DEF,
  parameter int INDEX_BITS = INDEX_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  lsra_cmd_t             cmd,
  output lsra_stat_t            stat,
  // request payload
  input  logic                  new_function,
  input  logic [VREG_W-1:0]     vreg_id,
  input  logic [REQ_IDX_W-1:0]  start_req,
  input  logic [REQ_IDX_W-1:0]  end_req,
  input  logic                  needs_vector,
  input  logic [LG_W-1:0]       slot_size_log2,
  input  logic [PRIO_W-1:0]     priority_req,
  // configuration
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [MASK_W-1:0]     cfg_data,
  // result
  input  logic                  res_ready,
  output logic                  res_valid,
  output logic [VREG_W-1:0]     vreg_out,
  output logic                  self_spilled,
  output logic                  is_vector,
  output logic [PHYS_OUT_W-1:0] phys_reg,
  output logic [OFFSET_W-1:0]   slot_offset,
  output logic                  victim_valid,
  output logic [VREG_W-1:0]     victim_vreg,
  output logic [OFFSET_W-1:0]   victim_offset,
  output logic [FRAME_W-1:0]    frame_bytes
);

  localparam int VW      = $clog2(NUM_VREGS);
  localparam int CW      = VW + 1;
  localparam int PW      = $clog2(NUM_PHYS);
  localparam int KW      = PW + 1;
  localparam int FILL_N  = (NUM_PHYS < MASK_W) ? NUM_PHYS : MASK_W;
  localparam int FW      = $clog2(FILL_N);
  localparam int MASK_IW = $clog2(MASK_W);
  // interval table entry layout
  localparam int E_LG    = 0;
  localparam int E_SP    = E_LG + LG_W;
  localparam int E_VEC   = E_SP + 1;
  localparam int E_REG   = E_VEC + 1;
  localparam int E_PRIO  = E_REG + PW;
  localparam int E_END   = E_PRIO + PRIO_W;
  localparam int EW      = E_END + INDEX_BITS;

  // Reduce a request vreg into the table range by shifted compare-subtract
  function automatic logic [VW-1:0] fold_vid(input logic [VREG_W-1:0] v);
    logic [VREG_W:0] r;
    r = {1'b0, v};
    for (int k = 4; k >= 0; k--) begin
      if ((NUM_VREGS << k) < 256 && int'(r) >= (NUM_VREGS << k)) begin
        r = r - (VREG_W + 1)'(NUM_VREGS << k);
      end
    end
    return VW'(r);
  endfunction

  // Configuration and stacks
  logic [MASK_W-1:0] scalar_mask, vector_mask;
  logic [PW-1:0]     stk_s [NUM_PHYS];
  logic [PW-1:0]     stk_v [NUM_PHYS];
  logic [KW-1:0]     cnt_s, cnt_v;
  logic [FW-1:0]     fr;

  // Captured request
  logic [VW-1:0]         it_vid;
  logic [INDEX_BITS-1:0] it_start, it_end;
  logic                  it_vec;
  logic [LG_W-1:0]       it_lg;
  logic [PRIO_W-1:0]     it_prio;

  // Walk state
  logic [CW-1:0] act_count, walk_i, walk_n;
  logic [VW-1:0] cur_a;
  logic          found;
  logic [VW-1:0] best_a;
  logic [EW-1:0] best_e;

  // Allocation result
  logic [PW-1:0]       r_reg;
  logic                r_spilled, r_vvalid;
  logic [OFFSET_W-1:0] r_off, r_voff;
  logic [FRAME_W-1:0]  spill_top;

  // Memories
  logic          act_we, tab_we;
  logic [VW-1:0] act_waddr, act_wdata, act_raddr, act_rdata;
  logic [VW-1:0] tab_waddr;
  logic [EW-1:0] tab_wdata, tab_rdata;

  lsra_ram #(.WIDTH(VW), .DEPTH(NUM_VREGS)) u_active (
    .clk(clk), .we(act_we), .waddr(act_waddr), .wdata(act_wdata),
    .raddr(act_raddr), .rdata(act_rdata)
  );

  lsra_ram #(.WIDTH(EW), .DEPTH(NUM_VREGS)) u_table (
    .clk(clk), .we(tab_we), .waddr(tab_waddr), .wdata(tab_wdata),
    .raddr(act_rdata), .rdata(tab_rdata)
  );

  // Fields of the entry under evaluation
  logic [INDEX_BITS-1:0] t_end;
  logic [PRIO_W-1:0]     t_prio;
  logic [PW-1:0]         t_reg;
  logic                  t_vec, t_sp;
  logic                  expired, push_en, cand;

  assign t_end   = tab_rdata[E_END +: INDEX_BITS];
  assign t_prio  = tab_rdata[E_PRIO +: PRIO_W];
  assign t_reg   = tab_rdata[E_REG +: PW];
  assign t_vec   = tab_rdata[E_VEC];
  assign t_sp    = tab_rdata[E_SP];
  assign expired = t_end < it_start;
  assign push_en = expired && !t_sp;
  assign cand    = !expired && (t_vec == it_vec) && !t_sp && (it_vec || t_end > it_end) &&
                   (!found || t_prio < best_e[E_PRIO +: PRIO_W]);

  // Pop source for the needed class
  logic [KW-1:0] cnt_c;
  logic          pop_en;
  logic [PW-1:0] pop_reg;
  assign cnt_c   = it_vec ? cnt_v : cnt_s;
  assign pop_en  = cnt_c != '0;
  assign pop_reg = it_vec ? stk_v[PW'(cnt_c - 1'b1)] : stk_s[PW'(cnt_c - 1'b1)];

  // Aligned slot in the spill area
  logic [LG_W-1:0]   slot_lg;
  logic [SLOT_W-1:0] slot_size, slot_mask, slot_base, slot_off;
  logic              slot_fit;
  assign slot_lg   = found ? best_e[E_LG +: LG_W] : it_lg;
  assign slot_size = SLOT_W'(1) << slot_lg;
  assign slot_mask = slot_size - 1'b1;
  assign slot_base = (SLOT_W'(spill_top) + slot_mask) & ~slot_mask;
  assign slot_fit  = (slot_base + slot_size) <= SLOT_W'(SPILL_LIMIT);
  assign slot_off  = slot_fit ? slot_base : SLOT_W'(SPILL_LIMIT) - slot_size;

  // Status to the controller
  assign stat.fill_last  = fr == FW'(FILL_N - 1);
  assign stat.walk_empty = walk_i >= act_count;
  assign stat.walk_last  = (walk_i + 1'b1) >= act_count;
  assign stat.out_free   = !res_valid || res_ready;
  assign stat.req_new    = new_function;

  // Active list port: survivors compact in place, new interval appends
  assign act_raddr = cmd.eval ? VW'(walk_i + 1'b1) : VW'(walk_i);
  assign act_we    = (cmd.eval && !expired) ||
                     (cmd.commit && act_count < CW'(NUM_VREGS));
  assign act_waddr = cmd.eval ? VW'(walk_n) : VW'(act_count);
  assign act_wdata = cmd.eval ? cur_a : it_vid;

  // Table port: victim gets marked spilled, then the new entry lands
  always_comb begin
    tab_we    = (cmd.alloc && !pop_en && found) || cmd.commit;
    tab_waddr = cmd.alloc ? best_a : it_vid;
    if (cmd.alloc) begin
      tab_wdata       = best_e;
      tab_wdata[E_SP] = 1'b1;
    end else begin
      tab_wdata = {it_end, it_prio, (r_spilled ? PW'(0) : r_reg), it_vec, r_spilled, it_lg};
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      scalar_mask <= SCALAR_RESET;
      vector_mask <= VECTOR_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SCALAR_MASK: scalar_mask <= cfg_data;
        CFG_VECTOR_MASK: vector_mask <= cfg_data;
        default: ;
      endcase
    end
  end

  // Free stacks: refill sweep, push on expiry, pop on allocation
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_s <= '0;
      cnt_v <= '0;
      fr    <= '0;
    end else if (cmd.capture && new_function) begin
      cnt_s <= '0;
      cnt_v <= '0;
      fr    <= '0;
    end else if (cmd.fill_step) begin
      fr <= fr + 1'b1;
      if (scalar_mask[MASK_IW'(fr)]) begin
        stk_s[PW'(cnt_s)] <= PW'(fr);
        cnt_s <= cnt_s + 1'b1;
      end
      if (vector_mask[MASK_IW'(fr)]) begin
        stk_v[PW'(cnt_v)] <= PW'(fr);
        cnt_v <= cnt_v + 1'b1;
      end
    end else if (cmd.eval && push_en) begin
      // drop the push when the stack is full
      if (t_vec && cnt_v < KW'(NUM_PHYS)) begin
        stk_v[PW'(cnt_v)] <= t_reg;
        cnt_v <= cnt_v + 1'b1;
      end else if (!t_vec && cnt_s < KW'(NUM_PHYS)) begin
        stk_s[PW'(cnt_s)] <= t_reg;
        cnt_s <= cnt_s + 1'b1;
      end
    end else if (cmd.alloc && pop_en) begin
      if (it_vec) cnt_v <= cnt_v - 1'b1;
      else        cnt_s <= cnt_s - 1'b1;
    end
  end

  // Capture the request
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      it_vid   <= fold_vid(vreg_id);
      it_start <= INDEX_BITS'(start_req);
      it_end   <= INDEX_BITS'(end_req);
      it_vec   <= needs_vector;
      it_lg    <= (slot_size_log2 > SLOT_LG_MAX) ? SLOT_LG_FALLBACK : slot_size_log2;
      it_prio  <= priority_req;
    end
  end

  // Walk over the active list: expire, compact, track the victim
  always_ff @(posedge clk) begin
    if (rst) begin
      act_count <= '0;
      walk_i    <= '0;
      walk_n    <= '0;
      found     <= 1'b0;
    end else if (cmd.capture) begin
      walk_i <= '0;
      walk_n <= '0;
      found  <= 1'b0;
      if (new_function) act_count <= '0;
    end else if (cmd.eval) begin
      walk_i <= walk_i + 1'b1;
      if (!expired) walk_n <= walk_n + 1'b1;
      if (cand)     found  <= 1'b1;
    end else if (cmd.alloc) begin
      act_count <= walk_n;
    end else if (cmd.commit && act_count < CW'(NUM_VREGS)) begin
      act_count <= act_count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tab_rd) cur_a <= act_rdata;
    if (cmd.eval && cand) begin
      best_a <= cur_a;
      best_e <= tab_rdata;
    end
  end

  // Spill area top
  always_ff @(posedge clk) begin
    if (rst) begin
      spill_top <= '0;
    end else if (cmd.capture && new_function) begin
      spill_top <= '0;
    end else if (cmd.alloc && !pop_en) begin
      spill_top <= slot_fit ? FRAME_W'(slot_base + slot_size) : FRAME_W'(SPILL_LIMIT);
    end
  end

  // Allocation decision
  always_ff @(posedge clk) begin
    if (cmd.alloc) begin
      r_spilled <= !pop_en && !found;
      r_vvalid  <= !pop_en && found;
      r_reg     <= pop_en ? pop_reg : (found ? best_e[E_REG +: PW] : PW'(0));
      r_off     <= (!pop_en && !found) ? OFFSET_W'(slot_off) : '0;
      r_voff    <= (!pop_en && found) ? OFFSET_W'(slot_off) : '0;
    end
  end

  // Result register
  logic [SLOT_W-1:0] frame_sum;
  assign frame_sum = (SLOT_W'(spill_top) + FRAME_ROUND) & ~FRAME_ROUND;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.commit) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      vreg_out      <= VREG_W'(it_vid);
      self_spilled  <= r_spilled;
      is_vector     <= it_vec;
      phys_reg      <= PHYS_OUT_W'(r_reg);
      slot_offset   <= r_off;
      victim_valid  <= r_vvalid;
      victim_vreg   <= r_vvalid ? VREG_W'(best_a) : '0;
      victim_offset <= r_voff;
      frame_bytes   <= FRAME_W'(frame_sum);
    end
  end

endmodule

// ===== src/linear_scan_register_allocator.sv =====
// Linear-scan register allocator: takes one live interval per request in start order
// and returns one assignment (register, own spill slot, or an evicted victim). For each
// active interval, the walk over the active list reads the active RAM and then the
// interval-table RAM. A request with new_function set adds a stack refill that sweeps
// the first min(NUM_PHYS, 32) registers; the same refill runs after reset, with no request
// taken until it ends. Pool mask writes take effect at the next new_function; reset
// restores the default masks.
`include "linear_scan_register_allocator_defines.svh"

module linear_scan_register_allocator
  import lsra_pkg::*;
#(
  parameter int NUM_VREGS  = NUM_VREGS_DEF,
  parameter int NUM_PHYS   = NUM_PHYS_DEF,
  parameter int INDEX_BITS = INDEX_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  lsra_req_if.sink             req,
  lsra_res_if.source           res,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [MASK_W-1:0]    cfg_data
);

  lsra_cmd_t  cmd;
  lsra_stat_t stat;
  logic       req_ready;

  assign req.ready = req_ready;

  lsra_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  lsra_dp #(
    .NUM_VREGS  (NUM_VREGS),
    .NUM_PHYS   (NUM_PHYS),
    .INDEX_BITS (INDEX_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .new_function   (req.new_function),
    .vreg_id        (req.vreg_id),
    .start_req      (req.start_req),
    .end_req        (req.end_req),
    .needs_vector   (req.needs_vector),
    .slot_size_log2 (req.slot_size_log2),
    .priority_req   (req.priority_req),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .res_ready      (res.ready),
    .res_valid      (res.valid),
    .vreg_out       (res.vreg_out),
    .self_spilled   (res.self_spilled),
    .is_vector      (res.is_vector),
    .phys_reg       (res.phys_reg),
    .slot_offset    (res.slot_offset),
    .victim_valid   (res.victim_valid),
    .victim_vreg    (res.victim_vreg),
    .victim_offset  (res.victim_offset),
    .frame_bytes    (res.frame_bytes)
  );

  // One request at a time: no accept right after an accept
  `LSRA_ASSERT_NEXT(a_one_in_flight, clk, req.valid && req.ready, !req.ready)
  // Stack refill follows reset before any request is taken
  `LSRA_ASSERT_NEXT(a_refill_after_reset, clk, rst, !req.ready)
  // A spilled interval carries no register and no victim
  `LSRA_ASSERT_HOLD(a_spill_clean, clk, rst, res.valid && res.self_spilled, (res.phys_reg == '0) && !res.victim_valid)

endmodule
